// ===== hw/rtl/ubx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared codes, types and the NAV-PVT field table for the UBX frame parser.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam logic [7:0] SYNC_A  = 8'hB5;
  localparam logic [7:0] SYNC_B  = 8'h62;
  localparam logic [7:0] CLS_ACK = 8'h05;
  localparam logic [7:0] ID_ACK  = 8'h01;
  localparam logic [7:0] ID_NAK  = 8'h00;
  localparam logic [7:0] CLS_NAV = 8'h01;
  localparam logic [7:0] ID_PVT  = 8'h07;

  localparam logic [15:0] PVT_MIN_LEN = 16'd92;
  localparam int          HDR_BYTES   = 4;   // class, id, length lo/hi
  localparam int          OVERHEAD    = 6;   // header plus two checksum bytes

  localparam logic [31:0] HACC_LIMIT_RESET = 32'd10000;
  localparam logic [7:0]  FIX_3D           = 8'd3;
  localparam logic [7:0]  FIX_GNSS_DR      = 8'd4;

  typedef enum logic [2:0] {
    EVT_CKSUM = 3'd0,
    EVT_ACK   = 3'd1,
    EVT_NAK   = 3'd2,
    EVT_NAV   = 3'd3,
    EVT_OTHER = 3'd4
  } evt_t;

  typedef struct packed {
    logic req;   // one-cycle pulse: a frame has ended
    logic pvt;   // valid NAV-PVT frame, run the field decoder
    evt_t evt;   // single event when pvt is clear
  } frame_done_t;

  // Field numbers of the decoded run
  localparam logic [4:0] FLD_ITOW    = 5'd0;
  localparam logic [4:0] FLD_YEAR    = 5'd1;
  localparam logic [4:0] FLD_MONTH   = 5'd2;
  localparam logic [4:0] FLD_DAY     = 5'd3;
  localparam logic [4:0] FLD_HOUR    = 5'd4;
  localparam logic [4:0] FLD_MIN     = 5'd5;
  localparam logic [4:0] FLD_SEC     = 5'd6;
  localparam logic [4:0] FLD_FIX     = 5'd7;
  localparam logic [4:0] FLD_NUMSV   = 5'd8;
  localparam logic [4:0] FLD_LON     = 5'd9;
  localparam logic [4:0] FLD_LAT     = 5'd10;
  localparam logic [4:0] FLD_HMSL    = 5'd11;
  localparam logic [4:0] FLD_GSPEED  = 5'd12;
  localparam logic [4:0] FLD_HEADMOT = 5'd13;
  localparam logic [4:0] FLD_HACC    = 5'd14;
  localparam logic [4:0] FLD_VACC    = 5'd15;
  localparam logic [4:0] FLD_PDOP    = 5'd16;
  localparam logic [4:0] FLD_FLAGS   = 5'd17;

  // Decoder steps: three status bytes first, then one step per field
  localparam logic [4:0] STEP_VALID  = 5'd0;
  localparam logic [4:0] STEP_FLAGS  = 5'd1;
  localparam logic [4:0] STEP_FLAGS3 = 5'd2;
  localparam logic [4:0] N_PRE       = 5'd3;
  localparam logic [4:0] STEP_LAST   = N_PRE + FLD_FLAGS;

  // Payload offset of the first byte read in a step
  function automatic logic [6:0] step_off(input logic [4:0] step);
    logic [6:0] off;
    case (step)
      STEP_VALID:            off = 7'd11;
      STEP_FLAGS:            off = 7'd21;
      STEP_FLAGS3:           off = 7'd78;
      N_PRE + FLD_ITOW:      off = 7'd0;
      N_PRE + FLD_YEAR:      off = 7'd4;
      N_PRE + FLD_MONTH:     off = 7'd6;
      N_PRE + FLD_DAY:       off = 7'd7;
      N_PRE + FLD_HOUR:      off = 7'd8;
      N_PRE + FLD_MIN:       off = 7'd9;
      N_PRE + FLD_SEC:       off = 7'd10;
      N_PRE + FLD_FIX:       off = 7'd20;
      N_PRE + FLD_NUMSV:     off = 7'd23;
      N_PRE + FLD_LON:       off = 7'd24;
      N_PRE + FLD_LAT:       off = 7'd28;
      N_PRE + FLD_HMSL:      off = 7'd36;
      N_PRE + FLD_GSPEED:    off = 7'd60;
      N_PRE + FLD_HEADMOT:   off = 7'd64;
      N_PRE + FLD_HACC:      off = 7'd40;
      N_PRE + FLD_VACC:      off = 7'd44;
      N_PRE + FLD_PDOP:      off = 7'd76;
      default:               off = 7'd0;
    endcase
    return off;
  endfunction

  // Number of little-endian bytes read in a step
  function automatic logic [2:0] step_nb(input logic [4:0] step);
    logic [2:0] nb;
    case (step)
      STEP_VALID, STEP_FLAGS, STEP_FLAGS3:     nb = 3'd1;
      N_PRE + FLD_ITOW, N_PRE + FLD_LON, N_PRE + FLD_LAT, N_PRE + FLD_HMSL,
      N_PRE + FLD_GSPEED, N_PRE + FLD_HEADMOT, N_PRE + FLD_HACC,
      N_PRE + FLD_VACC:                       nb = 3'd4;
      N_PRE + FLD_YEAR, N_PRE + FLD_PDOP:     nb = 3'd2;
      N_PRE + FLD_MONTH, N_PRE + FLD_DAY, N_PRE + FLD_HOUR, N_PRE + FLD_MIN,
      N_PRE + FLD_SEC, N_PRE + FLD_FIX, N_PRE + FLD_NUMSV: nb = 3'd1;
      default:                                nb = 3'd0;
    endcase
    return nb;
  endfunction

  // Fields carried as signed 32-bit values
  function automatic logic step_sgn(input logic [4:0] step);
    logic s;
    case (step)
      N_PRE + FLD_LON, N_PRE + FLD_LAT, N_PRE + FLD_HMSL, N_PRE + FLD_GSPEED,
      N_PRE + FLD_HEADMOT: s = 1'b1;
      default:             s = 1'b0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ubx_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ubx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ubx_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_rx
// Byte receiver: sync hunt, frame store writes, running Fletcher sum and
// frame outcome.
// ----------------------------------------------------------------------------
module ubx_rx
  import ubx_pkg::*;
#(
  parameter int FRAME_STORE_BYTES = 100
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // rx_byte
  input  wire logic                                 dec_busy,
  output logic                                      wr_en,
  output logic      [$clog2(FRAME_STORE_BYTES)-1:0] wr_addr,
  output logic      [7:0]                           wr_data,
  output frame_done_t                               done
);

  localparam int IW = $clog2(FRAME_STORE_BYTES);

  logic          in_frame;
  logic [7:0]    prev_byte;
  logic [IW-1:0] idx;
  logic [7:0]    cls;
  logic [7:0]    msg_id;
  logic [7:0]    len_lo;
  logic [15:0]   dec_len;
  logic [7:0]    sum_a;
  logic [7:0]    sum_b;
  logic [7:0]    ck_a_rx;

  logic          accept;
  logic [7:0]    b;
  logic [16:0]   idx17;
  logic [15:0]   len_cur;
  logic          in_sum;
  logic [7:0]    sum_a_next;
  logic [7:0]    sum_b_next;
  logic          finish;
  logic          cksum_ok;
  evt_t          evt;
  logic          pvt;

  assign s_axis_tready = !dec_busy && !done.req;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign idx17         = 17'(idx);
  assign len_cur       = {b, len_lo};

  assign wr_en   = accept && in_frame;
  assign wr_addr = idx;
  assign wr_data = b;

  always_comb begin
    in_sum     = (idx17 < 17'(HDR_BYTES)) || (idx17 < 17'(dec_len) + 17'(HDR_BYTES));
    sum_a_next = sum_a + b;
    sum_b_next = sum_b + sum_a_next;
    finish     = (idx17 >= 17'(HDR_BYTES)) &&
                 (idx17 + 17'd1 == 17'(dec_len) + 17'(OVERHEAD));
    cksum_ok   = (ck_a_rx == sum_a) && (b == sum_b);
    pvt        = 1'b0;
    if (!cksum_ok) begin
      evt = EVT_CKSUM;
    end else if (cls == CLS_ACK && msg_id == ID_ACK) begin
      evt = EVT_ACK;
    end else if (cls == CLS_ACK && msg_id == ID_NAK) begin
      evt = EVT_NAK;
    end else if (cls == CLS_NAV && msg_id == ID_PVT && dec_len >= PVT_MIN_LEN) begin
      evt = EVT_NAV;
      pvt = 1'b1;
    end else begin
      evt = EVT_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      prev_byte <= 8'd0;
      done      <= '{req: 1'b0, pvt: 1'b0, evt: EVT_CKSUM};
    end else begin
      done.req <= accept && in_frame && finish;
      if (accept) begin
        prev_byte <= b;
        if (!in_frame) begin
          idx   <= '0;
          sum_a <= 8'd0;
          sum_b <= 8'd0;
          if (prev_byte == SYNC_A && b == SYNC_B) begin
            in_frame <= 1'b1;
          end
        end else begin
          idx <= idx + 1'b1;
          if (in_sum) begin
            sum_a <= sum_a_next;
            sum_b <= sum_b_next;
          end
          if (idx17 == 17'd0) begin
            cls <= b;
          end
          if (idx17 == 17'd1) begin
            msg_id <= b;
          end
          if (idx17 == 17'd2) begin
            len_lo <= b;
          end
          if (idx17 == 17'd3) begin
            dec_len <= len_cur;
            // drop a frame that cannot fit the store
            if (len_cur > 16'(FRAME_STORE_BYTES - OVERHEAD)) begin
              in_frame <= 1'b0;
            end
          end
          if (idx17 >= 17'(HDR_BYTES) && idx17 == 17'(dec_len) + 17'(HDR_BYTES)) begin
            ck_a_rx <= b;
          end
          if (finish) begin
            in_frame <= 1'b0;
            done.pvt <= pvt;
            done.evt <= evt;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ubx_pvt_dec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_pvt_dec
// Result sequencer: reads NAV-PVT fields from the frame store byte by byte
// and drives the result stream, or sends a single frame event.
// ----------------------------------------------------------------------------
module ubx_pvt_dec
  import ubx_pkg::*;
#(
  parameter int AW = 7
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire frame_done_t    done,
  input  wire logic [31:0]    hacc_limit,
  output logic                busy,
  output logic                rd_en,
  output logic      [AW-1:0]  rd_addr,
  input  wire logic [7:0]     rd_data,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic      [39:0]    m_axis_tdata,  // field_value[32:0], zero pad
  output logic      [7:0]     m_axis_tuser,  // event_res[2:0], field_id[7:3]
  output logic                m_axis_tlast   // last
);

  typedef enum logic [2:0] {
    D_IDLE,
    D_ADDR,
    D_CAP,
    D_EMIT,
    D_EVT
  } state_t;

  state_t      state;
  logic [4:0]  step;
  logic [2:0]  j;
  logic [31:0] acc;
  evt_t        evt_hold;
  logic [7:0]  valid_b;
  logic [7:0]  flags_b;
  logic [7:0]  flags3_b;
  logic [7:0]  fix;
  logic [31:0] hacc;

  evt_t        out_evt;
  logic [4:0]  out_fid;
  logic [32:0] out_val;

  logic        out_free;
  logic        out_load;
  logic [4:0]  fid;
  logic        vd;
  logic        vt;
  logic        fr;
  logic        tok;
  logic        fok;
  logic        nok;
  logic [32:0] val;

  assign busy          = (state != D_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = out_free && ((state == D_EMIT) || (state == D_EVT));
  assign m_axis_tdata  = {7'd0, out_val};
  assign m_axis_tuser  = {out_fid, out_evt};
  assign rd_en         = (state == D_ADDR) && (j != step_nb(step));
  assign rd_addr       = AW'(HDR_BYTES) + AW'(step_off(step)) + AW'(j);

  always_comb begin
    fid = step - N_PRE;
    vd  = valid_b[0];
    vt  = valid_b[1];
    fr  = valid_b[2];
    tok = vd && vt && fr;
    fok = flags_b[0] && !flags3_b[0];
    nok = fok && (fix == FIX_3D || fix == FIX_GNSS_DR) && (hacc <= hacc_limit);
    if (fid == FLD_FLAGS) begin
      val = {27'd0, nok, fok, tok, fr, vt, vd};
    end else if (step_sgn(step)) begin
      val = {acc[31], acc};
    end else begin
      val = {1'b0, acc};
    end
    // zero date and time when the receiver marks them invalid
    if (fid inside {[FLD_YEAR:FLD_DAY]} && !vd) begin
      val = '0;
    end
    if (fid inside {[FLD_HOUR:FLD_SEC]} && !vt) begin
      val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= D_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        D_IDLE: begin
          if (done.req) begin
            evt_hold <= done.evt;
            step     <= STEP_VALID;
            j        <= 3'd0;
            acc      <= 32'd0;
            state    <= done.pvt ? D_ADDR : D_EVT;
          end
        end
        D_ADDR: begin
          if (j == step_nb(step)) begin
            if (step < N_PRE) begin
              case (step)
                STEP_VALID: valid_b  <= acc[7:0];
                STEP_FLAGS: flags_b  <= acc[7:0];
                default:    flags3_b <= acc[7:0];
              endcase
              step <= step + 5'd1;
              j    <= 3'd0;
              acc  <= 32'd0;
            end else begin
              state <= D_EMIT;
            end
          end else begin
            state <= D_CAP;
          end
        end
        D_CAP: begin
          acc[8*j[1:0] +: 8] <= rd_data;
          j                  <= j + 3'd1;
          state              <= D_ADDR;
        end
        D_EMIT: begin
          if (out_free) begin
            out_evt       <= EVT_NAV;
            out_fid       <= fid;
            out_val       <= val;
            m_axis_tlast  <= (step == STEP_LAST);
            if (fid == FLD_FIX) begin
              fix <= acc[7:0];
            end
            if (fid == FLD_HACC) begin
              hacc <= acc;
            end
            if (step == STEP_LAST) begin
              state <= D_IDLE;
            end else begin
              step  <= step + 5'd1;
              j     <= 3'd0;
              acc   <= 32'd0;
              state <= D_ADDR;
            end
          end
        end
        D_EVT: begin
          if (out_free) begin
            out_evt       <= evt_hold;
            out_fid       <= 5'd0;
            out_val       <= 33'd0;
            m_axis_tlast  <= 1'b1;
            state         <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ubx_navpvt_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_navpvt_frame_parser
// UBX frame receiver with Fletcher-8 check and NAV-PVT field decoder.
//
//   channel  dir  signals                          content
//   s_axis   in   tvalid tready tdata[7:0]         rx_byte
//   m_axis   out  tvalid tready tdata tuser tlast  field_value / event, id / last
//   cfg      in   cfg_wr_en cfg_wr_data[31:0]      hacc_limit_mm
//
// A byte is taken every cycle while no frame end is pending or being decoded; the
// frame store RAM is written once per frame byte. At frame end input stalls
// while the decoder sends a single event or a NAV-PVT run: the decoder reads 46
// store bytes through the single read port, closes each of its 21 steps and
// emits 18 transfers. Output back-pressure lengthens this. Synchronous reset
// clears the hunt state and the output valid; the store needs none.
// ----------------------------------------------------------------------------
module ubx_navpvt_frame_parser
  import ubx_pkg::*;
#(
  parameter int FRAME_STORE_BYTES = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // field_value[32:0], zero pad
  output logic      [7:0]  m_axis_tuser,   // event_res[2:0], field_id[7:3]
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data     // hacc_limit_mm
);

  localparam int AW = $clog2(FRAME_STORE_BYTES);

  logic [31:0]   hacc_limit;
  logic          dec_busy;
  frame_done_t   done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hacc_limit <= HACC_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      hacc_limit <= cfg_wr_data;
    end
  end

  ubx_rx #(
    .FRAME_STORE_BYTES(FRAME_STORE_BYTES)
  ) u_rx (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .dec_busy     (dec_busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .done         (done)
  );

  ubx_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_STORE_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ubx_pvt_dec #(
    .AW(AW)
  ) u_dec (
    .clk          (clk),
    .rst          (rst),
    .done         (done),
    .hacc_limit   (hacc_limit),
    .busy         (dec_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // no byte transfer while the decoder owns the store
  a_stall_while_busy: assert property (@(posedge clk) disable iff (rst)
    dec_busy |-> !s_axis_tready)
    else $error("input accepted while decoder busy");

  // store is never written and read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("frame store write during decode read");

  // a frame end is only signaled to an idle decoder
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done.req |-> !dec_busy)
    else $error("frame end while decoder busy");

  // single events carry zero id and value and end the run
  a_event_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2:0] != EVT_NAV) |->
      (m_axis_tlast && m_axis_tuser[7:3] == 5'd0 && m_axis_tdata == 40'd0))
    else $error("malformed single event result");
`endif

endmodule
`default_nettype wire

// ===== tb/ubx_navpvt_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_navpvt_frame_parser_tb
// Self-checking bench for the UBX frame parser. Bytes stream in as directed
// frames (ACK/NAK, bad checksums, oversized and short frames, NAV-PVT at the
// accuracy limit, resync on the last checksum byte), then random frames and
// noise under several accuracy limits. A byte-level tracker predicts every
// event and decoded field; both stream sides stall at random.
// ----------------------------------------------------------------------------
module ubx_navpvt_frame_parser_tb;
  import ubx_pkg::*;

  localparam int STORE_BYTES   = 100;
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int TIMEOUT_NS    = 5_000_000;

  // checksum corruption modes for generated frames
  localparam int CK_GOOD  = 0;
  localparam int CK_BAD_A = 1;
  localparam int CK_BAD_B = 2;

  typedef struct {
    evt_t        ev;
    logic [4:0]  id;
    logic [32:0] value;
    logic        last;
  } parser_result_t;

  // Byte-level copy of the parser state; queues the results each byte causes
  class ubx_frame_tracker;
    logic [31:0]    hacc_limit;
    bit             in_frame;
    logic [7:0]     prev_byte;
    logic [7:0]     store [STORE_BYTES];
    int unsigned    stored;
    int unsigned    decl_len;
    parser_result_t pending_results[$];
    int             failures;

    function new();
      hacc_limit  = HACC_LIMIT_RESET;
      in_frame    = 1'b0;
      prev_byte   = 8'h00;
      stored      = 0;
      decl_len    = 0;
      failures    = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function logic [7:0] pay8(int unsigned off);
      int unsigned i;
      i = HDR_BYTES + off;
      return (i < STORE_BYTES) ? store[i] : 8'h00;
    endfunction

    function logic [15:0] pay16(int unsigned off);
      return {pay8(off + 1), pay8(off)};
    endfunction

    function logic [31:0] pay32(int unsigned off);
      return {pay16(off + 2), pay16(off)};
    endfunction

    function void push_result(evt_t ev, logic [4:0] id, logic [32:0] value, logic last);
      parser_result_t r;
      r.ev    = ev;
      r.id    = id;
      r.value = value;
      r.last  = last;
      pending_results.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned n;
      logic [7:0]  sum_a, sum_b, valid, nav_flags, nav_flags3, fix;
      logic        vd, vt, fr, tok, fok, nok;
      logic [31:0] hacc;
      logic [32:0] value [18];
      if (!in_frame) begin
        stored = 0;
        if (prev_byte == SYNC_A && b == SYNC_B) in_frame = 1'b1;
      end else begin
        if (stored < STORE_BYTES) store[stored] = b;
        stored++;
        if (stored > 3) begin
          decl_len = {store[3], store[2]};
          if (decl_len > STORE_BYTES - OVERHEAD) begin
            // drop oversized frame and hunt again
            in_frame = 1'b0;
          end else if (stored >= decl_len + OVERHEAD) begin
            in_frame = 1'b0;
            n = HDR_BYTES + decl_len;
            sum_a = 8'h00;
            sum_b = 8'h00;
            for (int unsigned i = 0; i < n && i < STORE_BYTES; i++) begin
              sum_a = sum_a + store[i];
              sum_b = sum_b + sum_a;
            end
            if (n + 1 >= STORE_BYTES || store[n] != sum_a || store[n + 1] != sum_b) begin
              push_result(EVT_CKSUM, 5'd0, 33'd0, 1'b1);
            end else if (store[0] == CLS_ACK && store[1] == ID_ACK) begin
              push_result(EVT_ACK, 5'd0, 33'd0, 1'b1);
            end else if (store[0] == CLS_ACK && store[1] == ID_NAK) begin
              push_result(EVT_NAK, 5'd0, 33'd0, 1'b1);
            end else if (store[0] == CLS_NAV && store[1] == ID_PVT &&
                         decl_len >= PVT_MIN_LEN) begin
              valid      = pay8(11);
              fix        = pay8(20);
              nav_flags  = pay8(21);
              nav_flags3 = pay8(78);
              hacc       = pay32(40);
              vd  = valid[0];
              vt  = valid[1];
              fr  = valid[2];
              tok = vd & vt & fr;
              fok = nav_flags[0] & ~nav_flags3[0];
              nok = fok && (fix == FIX_3D || fix == FIX_GNSS_DR) && hacc <= hacc_limit;
              value[FLD_ITOW]    = {1'b0, pay32(0)};
              value[FLD_YEAR]    = vd ? 33'(pay16(4)) : 33'd0;
              value[FLD_MONTH]   = vd ? 33'(pay8(6)) : 33'd0;
              value[FLD_DAY]     = vd ? 33'(pay8(7)) : 33'd0;
              value[FLD_HOUR]    = vt ? 33'(pay8(8)) : 33'd0;
              value[FLD_MIN]     = vt ? 33'(pay8(9)) : 33'd0;
              value[FLD_SEC]     = vt ? 33'(pay8(10)) : 33'd0;
              value[FLD_FIX]     = 33'(fix);
              value[FLD_NUMSV]   = 33'(pay8(23));
              value[FLD_LON]     = 33'($signed(pay32(24)));
              value[FLD_LAT]     = 33'($signed(pay32(28)));
              value[FLD_HMSL]    = 33'($signed(pay32(36)));
              value[FLD_GSPEED]  = 33'($signed(pay32(60)));
              value[FLD_HEADMOT] = 33'($signed(pay32(64)));
              value[FLD_HACC]    = {1'b0, hacc};
              value[FLD_VACC]    = {1'b0, pay32(44)};
              value[FLD_PDOP]    = 33'(pay16(76));
              value[FLD_FLAGS]   = 33'({nok, fok, tok, fr, vt, vd});
              for (int k = 0; k < 18; k++) begin
                push_result(EVT_NAV, 5'(k), value[k], k == int'(FLD_FLAGS));
              end
            end else begin
              push_result(EVT_OTHER, 5'd0, 33'd0, 1'b1);
            end
          end
        end
      end
      prev_byte = b;
    endfunction

    function void check_result(logic [39:0] data, logic [7:0] user, logic last);
      parser_result_t want;
      if (pending_results.size() == 0) begin
        if (failures < 10) begin
          $display("ERROR: unexpected result event=%0d field=%0d value=%h last=%b",
                   user[2:0], user[7:3], data[32:0], last);
        end
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (user[2:0] !== want.ev || user[7:3] !== want.id || data[32:0] !== want.value ||
          last !== want.last) begin
        if (failures < 10) begin
          $display("ERROR: expected event=%0d field=%0d value=%h last=%b",
                   want.ev, want.id, want.value, want.last);
          $display("       got      event=%0d field=%0d value=%h last=%b",
                   user[2:0], user[7:3], data[32:0], last);
        end
        failures++;
      end
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [7:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en     = 1'b0;
  logic [31:0] cfg_wr_data   = 32'd0;

  ubx_frame_tracker sb;
  logic [7:0]       payload_q[$];
  int               bytes_sent   = 0;
  bit               tx_burst     = 1'b0;
  bit               rx_burst     = 1'b0;

  always #4 clk = ~clk;

  ubx_navpvt_frame_parser #(
    .FRAME_STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Fletcher-8 over class, id, length and the current payload: {ck_b, ck_a}
  function automatic logic [15:0] frame_checksum(input logic [7:0] cls, input logic [7:0] id,
                                                 input logic [15:0] len);
    logic [7:0] a, b;
    logic [7:0] hdr [4];
    hdr = '{cls, id, len[7:0], len[15:8]};
    a = 8'h00;
    b = 8'h00;
    foreach (hdr[i]) begin
      a = a + hdr[i];
      b = b + a;
    end
    foreach (payload_q[i]) begin
      a = a + payload_q[i];
      b = b + a;
    end
    return {b, a};
  endfunction

  function automatic int random_ck();
    case ($urandom_range(0, 15))
      0:       return CK_BAD_A;
      1:       return CK_BAD_B;
      default: return CK_GOOD;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input logic [15:0] len,
                            input bit with_sync_a, input int ck_mode);
    logic [15:0] ck;
    ck = frame_checksum(cls, id, len);
    if (ck_mode == CK_BAD_A) ck[7:0] = ck[7:0] ^ (8'h01 << $urandom_range(0, 7));
    if (ck_mode == CK_BAD_B) ck[15:8] = ck[15:8] ^ (8'h01 << $urandom_range(0, 7));
    if (with_sync_a) send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(cls);
    send_byte(id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (payload_q[i]) send_byte(payload_q[i]);
    send_byte(ck[7:0]);
    send_byte(ck[15:8]);
  endtask

  task automatic fill_random(input int n);
    payload_q.delete();
    repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Random NAV-PVT payload with the status bytes and hAcc forced
  task automatic fill_pvt(input int n, input logic [7:0] valid, input logic [7:0] fix,
                          input bit gnss_ok, input bit llh_bad, input logic [31:0] hacc);
    fill_random(n);
    payload_q[11] = valid;
    payload_q[20] = fix;
    payload_q[21] = (payload_q[21] & 8'hFE) | {7'd0, gnss_ok};
    payload_q[78] = (payload_q[78] & 8'hFE) | {7'd0, llh_bad};
    payload_q[40] = hacc[7:0];
    payload_q[41] = hacc[15:8];
    payload_q[42] = hacc[23:16];
    payload_q[43] = hacc[31:24];
  endtask

  task automatic write_hacc_limit(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.hacc_limit = v;
  endtask

  // Finish any open frame, then wait for the parser to drain and go quiet
  task automatic settle();
    int waited;
    while (sb.in_frame) send_byte(8'h00);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n_bytes);
    int          b0, pick, len;
    logic [31:0] hacc;
    b0 = bytes_sent;
    while (bytes_sent - b0 < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 3))
          0:       hacc = sb.hacc_limit;
          1:       hacc = sb.hacc_limit + 32'd1;
          2:       hacc = sb.hacc_limit - 32'd1;
          default: hacc = $urandom();
        endcase
        len = $urandom_range(int'(PVT_MIN_LEN), STORE_BYTES - OVERHEAD);
        fill_pvt(len, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 5)),
                 $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0, hacc);
        send_frame(CLS_NAV, ID_PVT, 16'(len), 1'b1, random_ck());
      end else if (pick < 60) begin
        fill_random($urandom_range(0, 8));
        send_frame(CLS_ACK, 8'($urandom_range(0, 2)), 16'(payload_q.size()), 1'b1,
                   random_ck());
      end else if (pick < 75) begin
        fill_random($urandom_range(0, 24));
        send_frame(8'($urandom), 8'($urandom), 16'(payload_q.size()), 1'b1, random_ck());
      end else if (pick < 82) begin
        fill_random($urandom_range(0, int'(PVT_MIN_LEN) - 1));
        send_frame(CLS_NAV, ID_PVT, 16'(payload_q.size()), 1'b1, random_ck());
      end else if (pick < 87) begin
        fill_random($urandom_range(0, 4));
        send_frame(8'($urandom), 8'($urandom),
                   16'($urandom_range(STORE_BYTES - OVERHEAD + 1, 65535)), 1'b1, CK_GOOD);
      end else if (pick < 93) begin
        // truncated frame: the next frame's bytes land in its payload
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(0, 3) == 0) ? SYNC_A : 8'($urandom));
        end
      end
    end
  endtask

  // Result side: random stalls, check every transfer
  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [15:0] ck;
    logic [31:0] limits [4];
    sb = new();
    limits = '{32'd0, 32'hFFFF_FFFF, $urandom(), 32'($urandom_range(0, 20000))};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // false start: B5 B5 62 must still sync
    send_byte(SYNC_A);
    fill_random(2);
    send_frame(CLS_ACK, ID_ACK, 16'd2, 1'b1, CK_GOOD);
    fill_random(2);
    send_frame(CLS_ACK, ID_NAK, 16'd2, 1'b1, CK_GOOD);
    fill_random(1);
    send_frame(CLS_ACK, 8'hFF, 16'd1, 1'b1, CK_GOOD);
    fill_random(0);
    send_frame(8'h00, 8'h00, 16'd0, 1'b1, CK_GOOD);
    fill_random(2);
    send_frame(CLS_ACK, ID_ACK, 16'd2, 1'b1, CK_BAD_A);
    fill_random(2);
    send_frame(CLS_ACK, ID_NAK, 16'd2, 1'b1, CK_BAD_B);
    // oversized lengths drop the frame
    fill_random(2);
    send_frame(CLS_NAV, ID_PVT, 16'(STORE_BYTES - OVERHEAD + 1), 1'b1, CK_GOOD);
    fill_random(2);
    send_frame(CLS_NAV, ID_PVT, 16'hFFFF, 1'b1, CK_GOOD);
    // short NAV-PVT is an ordinary frame
    fill_random(0);
    send_frame(CLS_NAV, ID_PVT, 16'd0, 1'b1, CK_GOOD);
    fill_pvt(int'(PVT_MIN_LEN), 8'h06, FIX_3D, 1'b1, 1'b0, HACC_LIMIT_RESET);
    send_frame(CLS_NAV, ID_PVT, PVT_MIN_LEN, 1'b1, CK_GOOD);
    // last checksum byte of 0xB5 followed by 0x62 opens the next frame
    do begin
      fill_random(2);
      ck = frame_checksum(CLS_ACK, ID_ACK, 16'd2);
    end while (ck[15:8] != SYNC_A);
    send_frame(CLS_ACK, ID_ACK, 16'd2, 1'b1, CK_GOOD);
    fill_random(0);
    send_frame(CLS_ACK, ID_NAK, 16'd0, 1'b0, CK_GOOD);
    settle();

    foreach (limits[i]) begin
      write_hacc_limit(limits[i]);
      run_random(10);
      settle();
    end

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
